// ===== design/bayer_quad_stretch_debayer_unit_defines.svh =====
// Assertion macros shared by the debayer unit's RTL files.
`ifndef BAYER_QUAD_STRETCH_DEBAYER_UNIT_DEFINES_SVH
`define BAYER_QUAD_STRETCH_DEBAYER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BQSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BQSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bqsd_pkg.sv =====
// Shared constants and types of the Bayer quad stretch and debayer unit.
`default_nettype none

package bqsd_pkg;

    // Sample and pixel widths. The pixel conversion assumes PIXEL_BITS <= SAMPLE_BITS.
    localparam int SAMPLE_BITS = 10;
    localparam int PIXEL_BITS  = 8;

    // Largest sample value and twice it, with one spare bit.
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX    = '1;
    localparam logic [SAMPLE_BITS:0]   SAMPLE_MAX_W  = {1'b0, SAMPLE_MAX};
    localparam logic [SAMPLE_BITS:0]   SAMPLE_MAX_X2 = {SAMPLE_MAX, 1'b0};

    // Divider step counter: one quotient bit per step.
    localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);
    localparam logic [CNT_BITS-1:0] STEP_LAST = CNT_BITS'(SAMPLE_BITS);

    // Control states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_DIVIDE = 2'b10
    } state_t;

    // Per-lane control from the sequencer.
    typedef struct packed {
        logic start;
        logic step;
    } lane_ctl_t;

    // Stretch settings shared by all lanes.
    typedef struct packed {
        logic                   stretch_en;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
    } range_t;

endpackage

`default_nettype wire

// ===== design/bayer_quad_stretch_debayer_unit.sv =====
// Top level of the Bayer quad min-max stretch and debayer unit.
`default_nettype none
`include "bayer_quad_stretch_debayer_unit_defines.svh"

// A measure transaction (func 0) is taken every cycle while the unit is idle and folds
// the quad into the tracked minimum and maximum. A convert transaction (func 1) runs
// four lanes side by side, one per sample, each a restoring divider that yields one
// quotient bit per cycle; the pixel enters the output register once the division is done
// and that register is free, and input is ready again as the pixel appears. A result
// waiting in the output register does not block input, but the next convert holds its
// lanes until it frees. Configuration writes of stretch_enable are always accepted.
module bayer_quad_stretch_debayer_unit
    import bqsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   func,
    input  logic                   restart,
    input  logic [SAMPLE_BITS-1:0] red_sample,
    input  logic [SAMPLE_BITS-1:0] green_red_row,
    input  logic [SAMPLE_BITS-1:0] green_blue_row,
    input  logic [SAMPLE_BITS-1:0] blue_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIXEL_BITS-1:0]  red_out,
    output logic [PIXEL_BITS-1:0]  green_out,
    output logic [PIXEL_BITS-1:0]  blue_out
);

    function automatic logic [SAMPLE_BITS-1:0] min2(input logic [SAMPLE_BITS-1:0] a,
                                                   input logic [SAMPLE_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] max2(input logic [SAMPLE_BITS-1:0] a,
                                                   input logic [SAMPLE_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   stretch_en_reg, stretch_en_next;
    logic [SAMPLE_BITS-1:0] lowest_reg, lowest_next;
    logic [SAMPLE_BITS-1:0] highest_reg, highest_next;

    logic                   take_measure;
    logic                   take_convert;
    logic                   out_free;
    logic                   load;
    logic [SAMPLE_BITS-1:0] base_lo;
    logic [SAMPLE_BITS-1:0] base_hi;
    lane_ctl_t              lane_ctl;
    range_t                 range;
    logic [SAMPLE_BITS-1:0] n_red;
    logic [SAMPLE_BITS-1:0] n_green_r;
    logic [SAMPLE_BITS-1:0] n_green_b;
    logic [SAMPLE_BITS-1:0] n_blue;

    // Handshake decode.
    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign take_measure = in_valid && in_ready && !func;
    assign take_convert = in_valid && in_ready && func;
    assign out_free     = !out_valid || out_ready;

    // Configuration register.
    assign stretch_en_next = (cfg_valid && cfg_ready) ? cfg_data : stretch_en_reg;

    // Extreme tracking over the four samples of a measure transaction.
    always_comb
    begin
        base_lo      = restart ? SAMPLE_MAX : lowest_reg;
        base_hi      = restart ? '0 : highest_reg;
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        if (take_measure)
        begin
            lowest_next  = min2(min2(min2(base_lo, red_sample), min2(green_red_row,
                           green_blue_row)), blue_sample);
            highest_next = max2(max2(max2(base_hi, red_sample), max2(green_red_row,
                           green_blue_row)), blue_sample);
        end
    end

    // Sequencer: start the lanes, count the division steps, hand off to the merge stage.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        load           = 1'b0;
        lane_ctl.start = take_convert;
        lane_ctl.step  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (take_convert)
                begin
                    state_next = S_DIVIDE;
                    cnt_next   = '0;
                end
            end
            S_DIVIDE:
            begin
                if (cnt_reg != STEP_LAST)
                begin
                    lane_ctl.step = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            stretch_en_reg <= 1'b1;
            lowest_reg     <= SAMPLE_MAX;
            highest_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            stretch_en_reg <= stretch_en_next;
            lowest_reg     <= lowest_next;
            highest_reg    <= highest_next;
        end
    end

    // Four lanes, one per sample of the quad.
    assign range.stretch_en = stretch_en_reg;
    assign range.lo         = lowest_reg;
    assign range.hi         = highest_reg;

    bqsd_lane u_lane_red (
        .clk    (clk),
        .ctl    (lane_ctl),
        .range  (range),
        .sample (red_sample),
        .value  (n_red)
    );

    bqsd_lane u_lane_green_r (
        .clk    (clk),
        .ctl    (lane_ctl),
        .range  (range),
        .sample (green_red_row),
        .value  (n_green_r)
    );

    bqsd_lane u_lane_green_b (
        .clk    (clk),
        .ctl    (lane_ctl),
        .range  (range),
        .sample (green_blue_row),
        .value  (n_green_b)
    );

    bqsd_lane u_lane_blue (
        .clk    (clk),
        .ctl    (lane_ctl),
        .range  (range),
        .sample (blue_sample),
        .value  (n_blue)
    );

    // Merge stage with the output register.
    bqsd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .n_red     (n_red),
        .n_green_r (n_green_r),
        .n_green_b (n_green_b),
        .n_blue    (n_blue),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    // A finished division waits while the previous pixel is still held.
    `BQSD_ASSERT_NEXT(a_hold_when_full, clk, rst_n,
        (state_reg == S_DIVIDE) && (cnt_reg == STEP_LAST) && out_valid && !out_ready,
        (state_reg == S_DIVIDE), "finished division left while output was full")

    // The extremes move only on an accepted measure transaction.
    `BQSD_ASSERT_NEXT(a_extremes_stable, clk, rst_n, !take_measure,
        $stable(lowest_reg) && $stable(highest_reg), "extremes changed without a measure")

    // An accepted convert starts a fresh division.
    `BQSD_ASSERT_NEXT(a_convert_starts, clk, rst_n, take_convert,
        (state_reg == S_DIVIDE) && (cnt_reg == '0), "convert did not start the lanes")

    // A new pixel appears only at the end of a division.
    `BQSD_ASSERT_NOW(a_result_source, clk, rst_n, $rose(out_valid),
        $past(state_reg == S_DIVIDE), "result appeared without a division")

endmodule

`default_nettype wire

// ===== design/bqsd_lane.sv =====
// One stretch lane: clamps a sample and divides it into the measured range bit by bit.
`default_nettype none

module bqsd_lane
    import bqsd_pkg::*;
(
    input  logic                   clk,
    input  lane_ctl_t              ctl,
    input  range_t                 range,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [SAMPLE_BITS-1:0] value
);

    logic [SAMPLE_BITS-1:0]   clamped;
    logic [SAMPLE_BITS-1:0]   diff;
    logic [SAMPLE_BITS-1:0]   span;
    logic [2*SAMPLE_BITS-1:0] scaled;
    logic [2*SAMPLE_BITS:0]   numer;
    logic                     degenerate;
    logic [SAMPLE_BITS+1:0]   trial;
    logic [SAMPLE_BITS+1:0]   trial_sub;
    logic                     take;

    logic [SAMPLE_BITS:0]   rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] low_reg, low_next;
    logic [SAMPLE_BITS:0]   div_reg, div_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic                   fixed_reg, fixed_next;
    logic [SAMPLE_BITS-1:0] fixed_val_reg, fixed_val_next;

    // Clamp to the range and build the rounding numerator 2*(v-lo)*SMAX + d.
    always_comb
    begin
        if (sample < range.lo)
        begin
            clamped = range.lo;
        end
        else if (sample > range.hi)
        begin
            clamped = range.hi;
        end
        else
        begin
            clamped = sample;
        end
        diff       = clamped - range.lo;
        span       = range.hi - range.lo;
        scaled     = {diff, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, diff};
        numer      = {scaled, 1'b0} + {{(SAMPLE_BITS+1){1'b0}}, span};
        degenerate = (range.hi <= range.lo);
    end

    // One restoring division step: bring down the next numerator bit.
    always_comb
    begin
        trial     = {rem_reg, low_reg[SAMPLE_BITS-1]};
        trial_sub = trial - {1'b0, div_reg};
        take      = (trial >= {1'b0, div_reg});
    end

    // Load on start, iterate on step, otherwise hold.
    always_comb
    begin
        rem_next       = rem_reg;
        low_next       = low_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        fixed_next     = fixed_reg;
        fixed_val_next = fixed_val_reg;
        if (ctl.start)
        begin
            rem_next       = numer[2*SAMPLE_BITS:SAMPLE_BITS];
            low_next       = numer[SAMPLE_BITS-1:0];
            div_next       = {span, 1'b0};
            quo_next       = '0;
            fixed_next     = !range.stretch_en || degenerate;
            fixed_val_next = range.stretch_en ? '0 : sample;
        end
        else if (ctl.step)
        begin
            rem_next = take ? trial_sub[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
            low_next = {low_reg[SAMPLE_BITS-2:0], 1'b0};
            quo_next = {quo_reg[SAMPLE_BITS-2:0], take};
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        low_reg       <= low_next;
        div_reg       <= div_next;
        quo_reg       <= quo_next;
        fixed_reg     <= fixed_next;
        fixed_val_reg <= fixed_val_next;
    end

    assign value = fixed_reg ? fixed_val_reg : quo_reg;

endmodule

`default_nettype wire

// ===== design/bqsd_merge.sv =====
// Merge stage: averages the greens, scales the lanes to pixel width and holds the result.
`default_nettype none

module bqsd_merge
    import bqsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [SAMPLE_BITS-1:0] n_red,
    input  logic [SAMPLE_BITS-1:0] n_green_r,
    input  logic [SAMPLE_BITS-1:0] n_green_b,
    input  logic [SAMPLE_BITS-1:0] n_blue,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [PIXEL_BITS-1:0]  red_out,
    output logic [PIXEL_BITS-1:0]  green_out,
    output logic [PIXEL_BITS-1:0]  blue_out
);

    // floor(n * PMAX / SMAX); division by 2^k-1 folds the high part back in.
    function automatic logic [PIXEL_BITS-1:0] to_pixel(input logic [SAMPLE_BITS-1:0] n);
        logic [SAMPLE_BITS+PIXEL_BITS-1:0] p;
        logic [PIXEL_BITS-1:0]             a;
        logic [SAMPLE_BITS-1:0]            b;
        logic [SAMPLE_BITS:0]              s;
        logic [PIXEL_BITS+1:0]             q;
        p = {n, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, n};
        a = p[SAMPLE_BITS+PIXEL_BITS-1:SAMPLE_BITS];
        b = p[SAMPLE_BITS-1:0];
        s = {1'b0, b} + (SAMPLE_BITS+1)'(a);
        q = (PIXEL_BITS+2)'(a) + (PIXEL_BITS+2)'(s >= SAMPLE_MAX_W)
            + (PIXEL_BITS+2)'(s >= SAMPLE_MAX_X2);
        return q[PIXEL_BITS-1:0];
    endfunction

    logic [SAMPLE_BITS:0]   green_sum;
    logic [SAMPLE_BITS-1:0] green_avg;

    logic                  out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0] red_reg, red_next;
    logic [PIXEL_BITS-1:0] green_reg, green_next;
    logic [PIXEL_BITS-1:0] blue_reg, blue_next;

    // Combine the lane results into one pixel.
    always_comb
    begin
        green_sum = {1'b0, n_green_r} + {1'b0, n_green_b};
        green_avg = green_sum[SAMPLE_BITS:1];
        red_next   = load ? to_pixel(n_red) : red_reg;
        green_next = load ? to_pixel(green_avg) : green_reg;
        blue_next  = load ? to_pixel(n_blue) : blue_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

`default_nettype wire

// ===== tb/tb_bayer_quad_stretch_debayer_unit.sv =====
// Self-checking testbench for the Bayer quad min-max stretch and debayer unit.
`timescale 1ns / 1ps

module tb_bayer_quad_stretch_debayer_unit
    import bqsd_pkg::*;
();

    // Function codes of an input transaction.
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    localparam int PIX_MAX      = (1 << PIXEL_BITS) - 1;
    localparam int SMAX_INT     = (1 << SAMPLE_BITS) - 1;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] red;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] blue;
    } pixel_t;

    typedef enum logic {
        ROW_QUAD        = 1'b0,
        ROW_SET_STRETCH = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      fn;
        logic      rs;
        sample_t   r;
        sample_t   gr;
        sample_t   gb;
        sample_t   b;
        logic      typed;
        pixel_t    px;
        logic      stretch_value;
    } stim_row_t;

    // Clock, reset and block inputs, all known from time zero.
    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_data = 1'b0;
    logic    in_valid = 1'b0;
    logic    func = FUNC_MEASURE;
    logic    restart = 1'b0;
    sample_t red_sample = '0;
    sample_t green_red_row = '0;
    sample_t green_blue_row = '0;
    sample_t blue_sample = '0;
    logic    out_ready = 1'b0;

    logic                  cfg_ready;
    logic                  in_ready;
    logic                  out_valid;
    logic [PIXEL_BITS-1:0] red_out;
    logic [PIXEL_BITS-1:0] green_out;
    logic [PIXEL_BITS-1:0] blue_out;

    // Hand-computed expectation that travels with the input transaction.
    logic   typed_flag = 1'b0;
    pixel_t typed_pixel = '0;

    // Predictor state: stretch setting and tracked extremes.
    logic    stretch_on = 1'b1;
    sample_t track_lo = SAMPLE_MAX;
    sample_t track_hi = '0;

    pixel_t pending_pixels[$];
    int     mismatch_count = 0;
    int     sent_quads = 0;
    int     cycle_count = 0;
    int     tx_pct = 0;
    int     rx_pct = 0;
    logic   stall_hold = 1'b0;
    logic   pressure_go = 1'b0;

    stim_row_t directed_rows[$];

    bayer_quad_stretch_debayer_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .restart        (restart),
        .red_sample     (red_sample),
        .green_red_row  (green_red_row),
        .green_blue_row (green_blue_row),
        .blue_sample    (blue_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out)
    );

    always #5 clk = ~clk;

    // Maps one sample onto the full range measured in the first pass.
    function automatic int stretch_level(input sample_t v);
        int c;
        int d;
        if (!stretch_on)
            return int'(v);
        if (track_hi <= track_lo)
            return 0;
        c = int'(v);
        if (c < int'(track_lo))
            c = int'(track_lo);
        if (c > int'(track_hi))
            c = int'(track_hi);
        d = int'(track_hi) - int'(track_lo);
        return (2 * (c - int'(track_lo)) * SMAX_INT + d) / (2 * d);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] level_to_pixel(input int n);
        return PIXEL_BITS'((n * PIX_MAX) / SMAX_INT);
    endfunction

    // Expected RGB pixel of a convert transaction under the current state.
    function automatic pixel_t predict_pixel(input sample_t r, input sample_t gr,
                                             input sample_t gb, input sample_t b);
        pixel_t p;
        p.red   = level_to_pixel(stretch_level(r));
        p.green = level_to_pixel((stretch_level(gr) + stretch_level(gb)) / 2);
        p.blue  = level_to_pixel(stretch_level(b));
        return p;
    endfunction

    // Folds one sample into the tracked extremes.
    task automatic track_sample(input sample_t v);
        if (v < track_lo)
            track_lo = v;
        if (v > track_hi)
            track_hi = v;
    endtask

    // Monitors: configuration, result checking and prediction at acceptance.
    always @(posedge clk)
    begin : monitor
        pixel_t want;
        pixel_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                stretch_on = cfg_data;

            if (out_valid && out_ready)
            begin
                got = '{red: red_out, green: green_out, blue: blue_out};
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("ERROR: unexpected pixel r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("ERROR: pixel mismatch expected r=%0d g=%0d b=%0d,",
                                     want.red, want.green, want.blue,
                                     " got r=%0d g=%0d b=%0d",
                                     got.red, got.green, got.blue);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (func == FUNC_CONVERT)
                begin
                    if (typed_flag)
                        pending_pixels.push_back(typed_pixel);
                    else
                        pending_pixels.push_back(predict_pixel(red_sample, green_red_row,
                                                               green_blue_row, blue_sample));
                end
                else
                begin
                    if (restart)
                    begin
                        track_lo = SAMPLE_MAX;
                        track_hi = '0;
                    end
                    track_sample(red_sample);
                    track_sample(green_red_row);
                    track_sample(green_blue_row);
                    track_sample(blue_sample);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        out_ready <= !stall_hold && ($urandom_range(99, 0) >= rx_pct);
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic stim_row_t quad_row(input logic fn, input logic rs,
                                           input sample_t r, input sample_t gr,
                                           input sample_t gb, input sample_t b,
                                           input logic typed, input pixel_t px);
        stim_row_t row;
        row = '0;
        row.kind  = ROW_QUAD;
        row.fn    = fn;
        row.rs    = rs;
        row.r     = r;
        row.gr    = gr;
        row.gb    = gb;
        row.b     = b;
        row.typed = typed;
        row.px    = px;
        return row;
    endfunction

    function automatic stim_row_t stretch_row(input logic value);
        stim_row_t row;
        row = '0;
        row.kind          = ROW_SET_STRETCH;
        row.stretch_value = value;
        return row;
    endfunction

    // Offers one quad transaction after a random sender gap and waits for acceptance.
    task automatic send_quad(input logic fn, input logic rs, input sample_t r,
                             input sample_t gr, input sample_t gb, input sample_t b,
                             input logic typed, input pixel_t px);
        if (tx_pct != 0 && $urandom_range(99, 0) < tx_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < tx_pct);
        end
        in_valid       <= 1'b1;
        func           <= fn;
        restart        <= rs;
        red_sample     <= r;
        green_red_row  <= gr;
        green_blue_row <= gb;
        blue_sample    <= b;
        typed_flag     <= typed;
        typed_pixel    <= px;
        do @(posedge clk); while (!in_ready);
        sent_quads++;
    endtask

    // Stops offering input and waits until every expected pixel has arrived.
    // The extra edge lets the monitor record the last accepted transaction first.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stretch(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle_mode(input int mode);
        tx_pct = (mode == 0) ? 36 : (mode == 1) ? 60 : 0;
        rx_pct = (mode == 0) ? 60 : (mode == 1) ? 36 : 0;
    endtask

    function automatic sample_t pick(input int lo, input int hi);
        if (lo < 0)
            lo = 0;
        if (hi > SMAX_INT)
            hi = SMAX_INT;
        return sample_t'($urandom_range(hi, lo));
    endfunction

    function automatic sample_t any_sample();
        return sample_t'($urandom_range(SMAX_INT, 0));
    endfunction

    // Random frames: a measure pass then a convert pass, with some noise and broken frames.
    task automatic run_frames(input int target);
        int     style;
        int     wlo;
        int     whi;
        int     n_meas;
        int     n_conv;
        int     kind;
        logic   fn;
        pixel_t none;
        none = '0;
        target = sent_quads + target;
        while (sent_quads < target)
        begin
            kind = $urandom_range(9, 0);
            if (kind <= 7)
            begin
                style = $urandom_range(3, 0);
                wlo = $urandom_range(SMAX_INT, 0);
                case (style)
                    0: begin wlo = 0; whi = SMAX_INT; end
                    1: whi = wlo + $urandom_range(15, 1);
                    2: whi = wlo;
                    default: whi = wlo + $urandom_range(400, 16);
                endcase
                if (whi > SMAX_INT)
                    whi = SMAX_INT;
                n_meas = $urandom_range(4, 1);
                for (int i = 0; i < n_meas; i++)
                    send_quad(FUNC_MEASURE, (i == 0) || ($urandom_range(9, 0) == 0),
                              pick(wlo, whi), pick(wlo, whi), pick(wlo, whi), pick(wlo, whi),
                              1'b0, none);
                n_conv = $urandom_range(10, 2);
                for (int i = 0; i < n_conv; i++)
                begin
                    if ($urandom_range(5, 0) == 0)
                        send_quad(FUNC_CONVERT, 1'($urandom_range(1, 0)), any_sample(),
                                  any_sample(), any_sample(), any_sample(), 1'b0, none);
                    else
                        send_quad(FUNC_CONVERT, 1'($urandom_range(1, 0)),
                                  pick(wlo - 8, whi + 8), pick(wlo - 8, whi + 8),
                                  pick(wlo - 8, whi + 8), pick(wlo - 8, whi + 8),
                                  1'b0, none);
                end
            end
            else if (kind == 8)
            begin
                // Noise: a single transaction with every field random.
                fn = 1'($urandom_range(1, 0));
                send_quad(fn, 1'($urandom_range(1, 0)), any_sample(), any_sample(),
                          any_sample(), any_sample(), 1'b0, none);
            end
            else
            begin
                // Broken frame: converts on whatever extremes are left over.
                n_conv = $urandom_range(4, 1);
                for (int i = 0; i < n_conv; i++)
                    send_quad(FUNC_CONVERT, 1'($urandom_range(1, 0)), any_sample(),
                              any_sample(), any_sample(), any_sample(), 1'b0, none);
            end
        end
    endtask

    // Main sequence: reset, directed table, random phases, final check.
    initial
    begin
        stim_row_t row;

        // Directed stimulus; typed pixels are read straight off the definition.
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b1, 10'd1023, 10'd1023, 10'd1023,
                                         10'd1023, 1'b1, '{8'd0, 8'd0, 8'd0}));
        directed_rows.push_back(stretch_row(1'b1));
        directed_rows.push_back(quad_row(FUNC_MEASURE, 1'b1, 10'd0, 10'd1023, 10'd512,
                                         10'd300, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd1023, 10'd1023, 10'd1023,
                                         10'd1023, 1'b1, '{8'd255, 8'd255, 8'd255}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0,
                                         1'b1, '{8'd0, 8'd0, 8'd0}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd512, 10'd100, 10'd900,
                                         10'd37, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'h2AA, 10'h155, 10'h155,
                                         10'h2AA, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_MEASURE, 1'b1, 10'd200, 10'd200, 10'd200,
                                         10'd200, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd200, 10'd200, 10'd200,
                                         10'd200, 1'b1, '{8'd0, 8'd0, 8'd0}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd0, 10'd1023, 10'd5,
                                         10'd700, 1'b1, '{8'd0, 8'd0, 8'd0}));
        directed_rows.push_back(quad_row(FUNC_MEASURE, 1'b0, 10'd100, 10'd300, 10'd250,
                                         10'd150, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd50, 10'd350, 10'd99,
                                         10'd301, 1'b1, '{8'd0, 8'd127, 8'd255}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd200, 10'd150, 10'd251,
                                         10'd299, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_MEASURE, 1'b1, 10'h155, 10'h2AA, 10'h155,
                                         10'h2AA, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'h200, 10'h1FF, 10'h300,
                                         10'h100, 1'b0, '0));
        directed_rows.push_back(stretch_row(1'b0));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd1023, 10'd1023, 10'd1023,
                                         10'd1023, 1'b1, '{8'd255, 8'd255, 8'd255}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b1, 10'd0, 10'd0, 10'd0, 10'd0,
                                         1'b1, '{8'd0, 8'd0, 8'd0}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd1023, 10'd0, 10'd1023,
                                         10'd0, 1'b1, '{8'd255, 8'd127, 8'd0}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd512, 10'd513, 10'd514,
                                         10'd1, 1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_MEASURE, 1'b1, 10'd7, 10'd7, 10'd7, 10'd7,
                                         1'b0, '0));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd7, 10'd8, 10'd9, 10'd10,
                                         1'b0, '0));
        directed_rows.push_back(stretch_row(1'b1));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd7, 10'd8, 10'd9, 10'd10,
                                         1'b1, '{8'd0, 8'd0, 8'd0}));
        directed_rows.push_back(quad_row(FUNC_CONVERT, 1'b0, 10'd1023, 10'd3, 10'd600,
                                         10'd6, 1'b0, '0));

        // Reset held, then released.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle_mode(0);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_SET_STRETCH)
            begin
                drain_outputs();
                write_stretch(row.stretch_value);
            end
            else
                send_quad(row.fn, row.rs, row.r, row.gr, row.gb, row.b, row.typed, row.px);
        end
        drain_outputs();

        // Random phases, each with a short bypass stretch at its end.
        for (int mode = 0; mode < 3; mode++)
        begin
            set_idle_mode(mode);
            if (mode == 0)
                pressure_go = 1'b1;
            run_frames(200);
            drain_outputs();
            write_stretch(1'b0);
            run_frames(50);
            drain_outputs();
            write_stretch(1'b1);
        end

        drain_outputs();
        if (pending_pixels.size() != 0)
        begin
            mismatch_count++;
            $display("ERROR: %0d expected pixels never arrived", pending_pixels.size());
        end
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
